// ===== src/sliding_window_convergence_check_assert.svh =====
// Assertion macros for the sliding window convergence check.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_CONVERGENCE_CHECK_ASSERT_SVH
`define SLIDING_WINDOW_CONVERGENCE_CHECK_ASSERT_SVH

// Same-cycle implication.
`define SWCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/swcc_pkg.sv =====
// Shared constants and types for the sliding window convergence check.
// No dependencies.
package swcc_pkg;

  localparam int WINDOW    = 5;
  localparam int DIMENSIONS = 3;
  localparam int COMP_W    = 24;
  localparam int LIMIT_W   = 32;
  localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int VEC_W     = DIMENSIONS * COMP_W;
  localparam int DIFF_W    = COMP_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int SUM_W     = SQ_W + 2;

  typedef logic [VEC_W-1:0]   vec_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  typedef struct packed {
    logic valid;
    logic last;
  } swcc_pair_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic fits;
  } swcc_verdict_t;

endpackage

// ===== src/swcc_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module swcc_ram #(
  parameter int DEPTH = 5,
  parameter int WIDTH = 72,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/swcc_dist.sv =====
// Pair distance pipeline: difference, square, sum and limit compare.
// Depends on swcc_pkg; fed by the registered read ports of swcc_ram.
module swcc_dist
  import swcc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  swcc_pair_t    pair_i,
  input  vec_t          rd_a,
  input  vec_t          rd_b,
  input  limit_t        limit,
  output swcc_verdict_t verdict
);

  swcc_pair_t p1_r, p2_r, p3_r;
  swcc_verdict_t verdict_r;
  logic signed [DIFF_W-1:0] diff_r [DIMENSIONS];
  logic signed [SQ_W-1:0]   prod   [DIMENSIONS];
  logic [SQ_W-1:0]          sq_r   [DIMENSIONS];
  logic [SUM_W-1:0]         sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r      <= '0;
      p2_r      <= '0;
      p3_r      <= '0;
      verdict_r <= '0;
    end else begin
      p1_r           <= pair_i;
      p2_r           <= p1_r;
      p3_r           <= p2_r;
      verdict_r.valid <= p3_r.valid;
      verdict_r.last  <= p3_r.last;
      verdict_r.fits  <= (sum <= SUM_W'(limit));
    end
  end

  always_comb begin
    for (int k = 0; k < DIMENSIONS; k++) begin
      prod[k] = diff_r[k] * diff_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIMENSIONS; k++) begin
      diff_r[k] <= {rd_a[k*COMP_W+COMP_W-1], rd_a[k*COMP_W +: COMP_W]}
                 - {rd_b[k*COMP_W+COMP_W-1], rd_b[k*COMP_W +: COMP_W]};
      sq_r[k]   <= $unsigned(prod[k]);
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < DIMENSIONS; k++) begin
      sum = sum + SUM_W'(sq_r[k]);
    end
  end

  assign verdict = verdict_r;

endmodule

// ===== src/sliding_window_convergence_check.sv =====
// Top level of the sliding window convergence check: control, window RAM, pair pipeline.
// Depends on swcc_pkg, swcc_ram and swcc_dist.
// Usage:
//   Input channel (in_valid/in_ready): in_action 0 pushes the vector
//   in_comp_0..2 into the window of the last five vectors; 1 clears the window.
//   Result channel (out_valid/out_ready): one out_converged per input transaction,
//   1 when the window is full and every pair lies within the distance limit.
//   Config channel (cfg_valid/cfg_ready): cfg_data writes the 32-bit squared
//   distance limit; cfg_ready is always high. Write only while idle.
// Timing:
//   In a push into a full window, the window RAM read ports visit the ten
//   pairs one per cycle, then the pipeline drains through the RAM read,
//   difference, square and verdict registers. One item is in work at a
//   time; the next is taken once the result is registered, even while
//   out_ready is low. A stalled receiver holds the result, and the next
//   result waits in the control until the slot frees.
// Reset:
//   Clears fill count, write slot and control; the limit returns to 16.
//   Window contents are not cleared and are read only after being written.
module sliding_window_convergence_check
  import swcc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic signed [COMP_W-1:0] in_comp_0,
  input  logic signed [COMP_W-1:0] in_comp_1,
  input  logic signed [COMP_W-1:0] in_comp_2,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_converged,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LIMIT_W-1:0]       cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]      state_r, state_nxt;
  slot_t           slot_r, slot_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  slot_t           pi_r, pi_nxt, pj_r, pj_nxt;
  logic            issue_r, issue_nxt;
  logic            ok_r, ok_nxt;
  logic            res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_conv_r, out_conv_nxt;
  limit_t          limit_r;

  logic [COMP_W-1:0] comps [3];
  vec_t            wdata;
  vec_t            rd_a, rd_b;
  logic            accept, we, full_after, last_pair, out_free;
  swcc_pair_t      pair;
  swcc_verdict_t   verdict;

  assign comps[0] = in_comp_0;
  assign comps[1] = in_comp_1;
  assign comps[2] = in_comp_2;

  always_comb begin
    for (int k = 0; k < DIMENSIONS; k++) begin
      wdata[k*COMP_W +: COMP_W] = comps[k];
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign we         = accept && !in_action;
  assign full_after = (fill_r >= CNT_W'(WINDOW - 1));
  assign last_pair  = (pi_r == SLOT_W'(WINDOW - 2)) && (pj_r == SLOT_W'(WINDOW - 1));
  assign out_free   = !out_valid_r || out_ready;
  assign pair.valid = issue_r;
  assign pair.last  = last_pair;

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_converged = out_conv_r;

  swcc_ram #(
    .DEPTH (WINDOW),
    .WIDTH (VEC_W),
    .AW    (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (slot_r),
    .wdata   (wdata),
    .raddr_a (pi_r),
    .raddr_b (pj_r),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  swcc_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .pair_i  (pair),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .limit   (limit_r),
    .verdict (verdict)
  );

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    pi_nxt        = pi_r;
    pj_nxt        = pj_r;
    issue_nxt     = issue_r;
    ok_nxt        = ok_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_conv_nxt  = out_conv_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action) begin
            slot_nxt  = '0;
            fill_nxt  = '0;
            res_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
            if (fill_r != CNT_W'(WINDOW)) begin
              fill_nxt = fill_r + 1'b1;
            end
            if (full_after) begin
              pi_nxt    = '0;
              pj_nxt    = SLOT_W'(1);
              issue_nxt = 1'b1;
              ok_nxt    = 1'b1;
              state_nxt = ST_SCAN;
            end else begin
              res_nxt   = 1'b0;
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_SCAN: begin
        if (issue_r) begin
          if (last_pair) begin
            issue_nxt = 1'b0;
          end else if (pj_r == SLOT_W'(WINDOW - 1)) begin
            pi_nxt = pi_r + 1'b1;
            pj_nxt = pi_r + SLOT_W'(2);
          end else begin
            pj_nxt = pj_r + 1'b1;
          end
        end
        if (verdict.valid) begin
          ok_nxt = ok_r && verdict.fits;
          if (verdict.last) begin
            res_nxt   = ok_r && verdict.fits;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_conv_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_W'(16);
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pi_r       <= pi_nxt;
    pj_r       <= pj_nxt;
    ok_r       <= ok_nxt;
    res_r      <= res_nxt;
    out_conv_r <= out_conv_nxt;
  end

endmodule

// ===== src/swcc_checker.sv =====
// Port-level checker for the sliding window convergence check, bound to the top level.
// Depends on sliding_window_convergence_check_assert.svh.
`include "sliding_window_convergence_check_assert.svh"

module swcc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_converged
);

  `SWCC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "in_ready high after transaction")
  `SWCC_ASSERT_NOW(a_ready_on_result, $rose(out_valid), in_ready, "result shown while busy")
  `SWCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")
  `SWCC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_converged), "result changed under stall")

endmodule

bind sliding_window_convergence_check swcc_checker u_swcc_checker (.*);
